FILE: rtl/core/utfdec_pkg.sv
// utfdec_pkg: shared types and constants of the UTF-8 / UTF-16 stream decoder
// no dependencies; used by utfdec_step and utf8_utf16_stream_decoder

package utfdec_pkg;

    // source_mode register codes; the fourth code fails every byte
    localparam logic [1:0] SRC_UTF8    = 2'd0;
    localparam logic [1:0] SRC_UTF16LE = 2'd1;
    localparam logic [1:0] SRC_UTF16BE = 2'd2;

    localparam logic [20:0] CP_MAX      = 21'h10FFFF;
    localparam logic [20:0] CP_SUPP     = 21'h10000;
    localparam logic [5:0]  SURR_HIGH   = 6'b110110;  // top bits of D800..DBFF
    localparam logic [5:0]  SURR_LOW    = 6'b110111;  // top bits of DC00..DFFF

    // message state carried from byte to byte
    typedef struct packed {
        logic [23:0] held_bytes;
        logic [2:0]  held_count;
        logic [2:0]  expected_count;
        logic [9:0]  high_surrogate;
        logic        surrogate_pending;
        logic        failed;
    } msg_state_t;

    // utf-8 bytes of one code point
    typedef struct packed {
        logic [3:0][7:0] bytes;
        logic [2:0]      n;
    } utf8_seq_t;

    // all results caused by one input byte
    typedef struct packed {
        logic [3:0][7:0] bytes;
        logic [2:0]      n;       // data bytes, 0..4
        logic            at_end;  // closes the message
        logic            err;     // message failed
    } result_group_t;

endpackage

FILE: rtl/core/utfdec_if.sv
// utfdec_in_if / utfdec_out_if: valid-ready channels of the stream decoder
// no package dependency; payload fields follow the byte and result items

interface utfdec_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;
    logic       end_of_message;

    modport source (output valid, output in_byte, output end_of_message, input ready);
    modport sink   (input valid, input in_byte, input end_of_message, output ready);
endinterface

interface utfdec_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       byte_valid;
    logic       decode_error;
    logic       message_done;
    logic       run_last;

    modport source (
        output valid, output out_byte, output byte_valid, output decode_error,
        output message_done, output run_last, input ready
    );
    modport sink (
        input valid, input out_byte, input byte_valid, input decode_error,
        input message_done, input run_last, output ready
    );
endinterface

FILE: rtl/core/utfdec_step.sv
// utfdec_step: combinational decode of one byte against the message state
// depends on utfdec_pkg; produces the next state and the result group

module utfdec_step (
    input  logic                       [1:0] mode,
    input  utfdec_pkg::msg_state_t           state,
    input  logic                       [7:0] in_byte,
    input  logic                             end_of_message,
    output utfdec_pkg::msg_state_t           state_next,
    output utfdec_pkg::result_group_t        group,
    output logic                             push
);
    import utfdec_pkg::*;

    function automatic utf8_seq_t put_utf8(input logic [20:0] cp);
        utf8_seq_t s;
        s = '0;
        if (cp < 21'h80) begin
            s.bytes[0] = {1'b0, cp[6:0]};
            s.n        = 3'd1;
        end else if (cp < 21'h800) begin
            s.bytes[0] = {3'b110, cp[10:6]};
            s.bytes[1] = {2'b10, cp[5:0]};
            s.n        = 3'd2;
        end else if (cp < CP_SUPP) begin
            s.bytes[0] = {4'b1110, cp[15:12]};
            s.bytes[1] = {2'b10, cp[11:6]};
            s.bytes[2] = {2'b10, cp[5:0]};
            s.n        = 3'd3;
        end else begin
            s.bytes[0] = {5'b11110, cp[20:18]};
            s.bytes[1] = {2'b10, cp[17:12]};
            s.bytes[2] = {2'b10, cp[11:6]};
            s.bytes[3] = {2'b10, cp[5:0]};
            s.n        = 3'd4;
        end
        return s;
    endfunction

    logic [7:0]      b0, b1, b2;
    msg_state_t      u8_st;
    logic [2:0]      u8_n;
    logic [3:0][7:0] u8_bytes;
    logic            u8_fail;
    logic [20:0]     u8_cp, u8_lo, u8_hi;

    msg_state_t      u16_st;
    logic [15:0]     unit;
    logic            is_high, is_low;
    logic [20:0]     pair_cp, u16_cp;
    logic            u16_emit, u16_fail;
    utf8_seq_t       u16_seq;

    msg_state_t      nxt;
    logic [2:0]      n;
    logic [3:0][7:0] bytes;
    logic            fail, err;

    assign b0 = state.held_bytes[7:0];
    assign b1 = state.held_bytes[15:8];
    assign b2 = state.held_bytes[23:16];

    // utf-8 validation
    always_comb
    begin
        u8_st    = state;
        u8_n     = 3'd0;
        u8_bytes = '0;
        u8_fail  = 1'b0;
        u8_cp    = '0;
        u8_lo    = '0;
        u8_hi    = '0;
        if (state.held_count == 3'd0) begin
            if (!in_byte[7]) begin
                u8_n        = 3'd1;
                u8_bytes[0] = in_byte;
            end else if (in_byte[7:5] == 3'b110 || in_byte[7:4] == 4'b1110
                         || in_byte[7:3] == 5'b11110)
            begin
                u8_st.held_bytes = {16'd0, in_byte};
                u8_st.held_count = 3'd1;
                if (in_byte[7:5] == 3'b110) begin
                    u8_st.expected_count = 3'd2;
                end else if (in_byte[7:4] == 4'b1110) begin
                    u8_st.expected_count = 3'd3;
                end else begin
                    u8_st.expected_count = 3'd4;
                end
            end else begin
                u8_fail = 1'b1;
            end
        end else if (in_byte[7:6] != 2'b10 || state.held_count > 3'd3
                     || state.expected_count > 3'd4)
        begin
            u8_fail = 1'b1;
        end else if ({1'b0, state.held_count} + 4'd1 < {1'b0, state.expected_count}) begin
            case (state.held_count[1:0])
                2'd1:    u8_st.held_bytes[15:8]  = in_byte;
                2'd2:    u8_st.held_bytes[23:16] = in_byte;
                default: u8_st.held_bytes[7:0]   = in_byte;
            endcase
            u8_st.held_count = state.held_count + 3'd1;
        end else begin
            case (state.expected_count)
                3'd2: begin
                    u8_cp = {10'd0, b0[4:0], in_byte[5:0]};
                    u8_lo = 21'h80;
                    u8_hi = 21'h7FF;
                end
                3'd3: begin
                    u8_cp = {5'd0, b0[3:0], b1[5:0], in_byte[5:0]};
                    u8_lo = 21'h800;
                    u8_hi = 21'hFFFF;
                end
                default: begin
                    u8_cp = {b0[2:0], b1[5:0], b2[5:0], in_byte[5:0]};
                    u8_lo = CP_SUPP;
                    u8_hi = CP_MAX;
                end
            endcase
            if (u8_cp < u8_lo || u8_cp > u8_hi) begin
                u8_fail = 1'b1;
            end else begin
                u8_n        = state.expected_count;
                u8_bytes[0] = b0;
                case (state.expected_count)
                    3'd2: u8_bytes[1] = in_byte;
                    3'd3: begin
                        u8_bytes[1] = b1;
                        u8_bytes[2] = in_byte;
                    end
                    default: begin
                        u8_bytes[1] = b1;
                        u8_bytes[2] = b2;
                        u8_bytes[3] = in_byte;
                    end
                endcase
                u8_st.held_bytes     = '0;
                u8_st.held_count     = 3'd0;
                u8_st.expected_count = 3'd0;
            end
        end
    end

    // utf-16 code unit assembly
    assign unit    = (mode == SRC_UTF16BE) ? {b0, in_byte} : {in_byte, b0};
    assign is_high = (unit[15:10] == SURR_HIGH);
    assign is_low  = (unit[15:10] == SURR_LOW);
    assign pair_cp = CP_SUPP + {1'b0, state.high_surrogate, unit[9:0]};

    always_comb
    begin
        u16_st   = state;
        u16_emit = 1'b0;
        u16_fail = 1'b0;
        u16_cp   = {5'd0, unit};
        if (state.held_count == 3'd0) begin
            u16_st.held_bytes = {16'd0, in_byte};
            u16_st.held_count = 3'd1;
        end else begin
            u16_st.held_bytes = '0;
            u16_st.held_count = 3'd0;
            if (state.surrogate_pending) begin
                if (is_low) begin
                    u16_cp                   = pair_cp;
                    u16_emit                 = 1'b1;
                    u16_st.high_surrogate    = '0;
                    u16_st.surrogate_pending = 1'b0;
                end else begin
                    u16_fail = 1'b1;
                end
            end else if (is_high) begin
                u16_st.high_surrogate    = unit[9:0];
                u16_st.surrogate_pending = 1'b1;
            end else if (is_low) begin
                u16_fail = 1'b1;
            end else begin
                u16_emit = 1'b1;
            end
        end
    end

    assign u16_seq = put_utf8(u16_cp);

    // mode select, error handling and end of message
    always_comb
    begin
        nxt   = state;
        n     = 3'd0;
        bytes = '0;
        fail  = 1'b0;
        err   = 1'b0;
        if (!state.failed) begin
            unique case (mode)
                SRC_UTF8: begin
                    nxt   = u8_st;
                    n     = u8_n;
                    bytes = u8_bytes;
                    fail  = u8_fail;
                end
                SRC_UTF16LE, SRC_UTF16BE: begin
                    nxt   = u16_st;
                    n     = u16_emit ? u16_seq.n : 3'd0;
                    bytes = u16_seq.bytes;
                    fail  = u16_fail;
                end
                default: fail = 1'b1;
            endcase
        end
        if (fail) begin
            nxt        = '0;
            nxt.failed = 1'b1;
            n          = 3'd0;
        end
        if (end_of_message) begin
            // truncated sequence, odd byte count or unpaired high surrogate
            if (nxt.held_count != 3'd0 || nxt.surrogate_pending) begin
                nxt.failed = 1'b1;
            end
            err = nxt.failed;
            if (nxt.failed) begin
                n = 3'd0;
            end
            nxt = '0;
        end
    end

    assign state_next   = nxt;
    assign group.bytes  = bytes;
    assign group.n      = n;
    assign group.at_end = end_of_message;
    assign group.err    = err;
    assign push         = end_of_message || (n != 3'd0);

endmodule

FILE: rtl/core/utf8_utf16_stream_decoder.sv
// utf8_utf16_stream_decoder: top level of the UTF-8 validator / UTF-16 to UTF-8 transcoder
// depends on utfdec_pkg, utfdec_if.sv (channels) and utfdec_step
//
// byte_stream takes one message byte per transaction, end_of_message on the last byte.
// result_stream delivers UTF-8 bytes; byte_valid is 0 on a status-only result.
// message_done marks the final result of a message, decode_error on it says the
// message failed; bytes already delivered for a failed message are to be dropped.
// run_last marks the last result caused by one input byte.
// cfg_we / cfg_wdata write source_mode (0 UTF-8, 1 UTF-16 LE, 2 UTF-16 BE); a write
// also clears the message state. The user must make a write only while the block is
// idle; the block itself does not enforce this. throughput: one input byte per cycle
// while the queue has room; each byte is decoded between the input register and a
// queue of FIFO_DEPTH result groups (up to four results each). the output side drains
// one result per cycle while the receiver is ready, so long runs of multi-byte code
// points are paced by the output port at one result per cycle. an accepted byte is held
// in the input register, decoded and its result group written to the queue. when the
// receiver stalls, the queue fills and then byte_stream.ready drops; nothing is lost.
// reset clears the mode to UTF-8, the message state and the queue.

module utf8_utf16_stream_decoder #(
    parameter int FIFO_DEPTH = 4
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_we,
    input  logic         [1:0] cfg_wdata,
    utfdec_in_if.sink          byte_stream,
    utfdec_out_if.source       result_stream
);
    import utfdec_pkg::*;

    localparam int PTR_W = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
    localparam int CNT_W = $clog2(FIFO_DEPTH + 1);

    logic [1:0]    mode_reg;
    msg_state_t    state_reg, state_next;

    logic          in_vld_reg;
    logic [7:0]    in_byte_reg;
    logic          in_end_reg;

    result_group_t group;
    logic          push, commit, in_ready;

    result_group_t fifo_mem [FIFO_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic          full, empty, push_fire, pop;

    result_group_t head;
    logic [1:0]    idx_reg;
    logic [1:0]    last_idx;
    logic          is_last, out_fire;

    utfdec_step u_step (
        .mode           (mode_reg),
        .state          (state_reg),
        .in_byte        (in_byte_reg),
        .end_of_message (in_end_reg),
        .state_next     (state_next),
        .group          (group),
        .push           (push)
    );

    assign full      = (cnt_reg == CNT_W'(FIFO_DEPTH));
    assign empty     = (cnt_reg == '0);
    assign commit    = in_vld_reg && (!push || !full);
    assign push_fire = commit && push;
    assign in_ready  = !in_vld_reg || commit;

    assign byte_stream.ready = in_ready;

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            in_vld_reg <= 1'b0;
        end else if (in_ready) begin
            in_vld_reg <= byte_stream.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && byte_stream.valid) begin
            in_byte_reg <= byte_stream.in_byte;
            in_end_reg  <= byte_stream.end_of_message;
        end
    end

    // mode register and message state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            mode_reg  <= SRC_UTF8;
            state_reg <= '0;
        end else if (cfg_we) begin
            mode_reg  <= cfg_wdata;
            state_reg <= '0;
        end else if (commit) begin
            state_reg <= state_next;
        end
    end

    // result group queue
    always_ff @(posedge clk)
    begin
        if (push_fire) begin
            fifo_mem[wr_ptr_reg] <= group;
        end
    end

    assign head     = fifo_mem[rd_ptr_reg];
    assign last_idx = (head.n == 3'd0) ? 2'd0 : 2'(head.n - 3'd1);
    assign is_last  = (idx_reg == last_idx);
    assign out_fire = result_stream.valid && result_stream.ready;
    assign pop      = out_fire && is_last;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
            idx_reg    <= '0;
        end else begin
            if (push_fire) begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(FIFO_DEPTH - 1)) ? '0
                                                                     : wr_ptr_reg + 1'b1;
            end
            if (pop) begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(FIFO_DEPTH - 1)) ? '0
                                                                     : rd_ptr_reg + 1'b1;
            end
            if (push_fire && !pop) begin
                cnt_reg <= cnt_reg + 1'b1;
            end else if (pop && !push_fire) begin
                cnt_reg <= cnt_reg - 1'b1;
            end
            if (pop) begin
                idx_reg <= '0;
            end else if (out_fire) begin
                idx_reg <= idx_reg + 1'b1;
            end
        end
    end

    // unpack the head group one result per transaction
    assign result_stream.valid        = !empty;
    assign result_stream.byte_valid   = ({1'b0, idx_reg} < head.n);
    assign result_stream.out_byte     = result_stream.byte_valid ? head.bytes[idx_reg] : 8'd0;
    assign result_stream.run_last     = is_last;
    assign result_stream.message_done = is_last && head.at_end;
    assign result_stream.decode_error = is_last && head.at_end && head.err;

    assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CNT_W'(FIFO_DEPTH))
        else $error("result queue count beyond depth");

    assert property (@(posedge clk) disable iff (!rst_n)
        push_fire && !pop |=> !empty)
        else $error("pushed group not visible in queue");

    assert property (@(posedge clk) disable iff (!rst_n)
        result_stream.valid |-> idx_reg <= last_idx)
        else $error("result index past end of group");

    assert property (@(posedge clk) disable iff (!rst_n)
        state_reg.failed |-> state_reg.held_count == 3'd0 && !state_reg.surrogate_pending)
        else $error("failed message still holds bytes");

    assert property (@(posedge clk) disable iff (!rst_n)
        commit && in_end_reg && !cfg_we |=> state_reg == '0)
        else $error("message state not cleared at end of message");

endmodule
